[rtl/core/cross_gradient_focus_map_defines.svh]
// Assertion helpers for the cross gradient block.
// Each expects clk and rst_n in the scope where it is used.
`ifndef CROSS_GRADIENT_FOCUS_MAP_DEFINES_SVH
`define CROSS_GRADIENT_FOCUS_MAP_DEFINES_SVH

// Same-cycle implication.
`define CGFM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CGFM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/cgfm_pkg.sv]
package cgfm_pkg;

  localparam int CGFM_MAX_WIDTH  = 4096;
  localparam int CGFM_MAX_HEIGHT = 4096;
  localparam int CFG_W           = 13;
  localparam int PIX_W           = 8;
  localparam int ROW_W           = 12;
  localparam int OUT_DEPTH       = 3;

  localparam logic [CFG_W-1:0] WIDTH_RESET  = 13'd640;
  localparam logic [CFG_W-1:0] HEIGHT_RESET = 13'd480;
  localparam logic [PIX_W-1:0] SAT_LIMIT    = 8'd255;

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_DRAIN = 1'b1;

  typedef enum logic {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic             kind;
    logic [PIX_W-1:0] pixel;
  } in_t;

  typedef struct packed {
    logic [PIX_W-1:0] gradient;
    logic             frame_end;
  } out_t;

  // one line buffer column: two rows back and one row back
  typedef struct packed {
    logic [PIX_W-1:0] above;
    logic [PIX_W-1:0] middle;
  } line_pair_t;

  // control of the transaction held in the memory read stage
  typedef struct packed {
    logic valid;
    logic pix;
    logic emit;
    logic interior;
    logic frame_end;
  } s1_ctl_t;

  function automatic logic [PIX_W-1:0] absdiff(input logic [PIX_W-1:0] a,
                                               input logic [PIX_W-1:0] b);
    absdiff = (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

[rtl/core/cgfm_line_mem.sv]
module cgfm_line_mem #(
  parameter int DEPTH = cgfm_pkg::CGFM_MAX_WIDTH
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  cgfm_pkg::line_pair_t     wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output cgfm_pkg::line_pair_t     rd_data_a,
  output cgfm_pkg::line_pair_t     rd_data_b
);
  import cgfm_pkg::*;

  line_pair_t mem [DEPTH];
  line_pair_t rd_a_r;
  line_pair_t rd_b_r;

  // read-first: a read at the written address returns the old entry
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_a_r <= mem[rd_addr_a];
    rd_b_r <= mem[rd_addr_b];
  end

  assign rd_data_a = rd_a_r;
  assign rd_data_b = rd_b_r;

endmodule

[rtl/core/cgfm_ctrl.sv]
module cgfm_ctrl #(
  parameter int MAX_WIDTH = cgfm_pkg::CGFM_MAX_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr,
  input  cgfm_pkg::cfg_reg_t           cfg_index,
  input  logic [cgfm_pkg::CFG_W-1:0]   cfg_data,
  input  logic                         in_accept,
  input  cgfm_pkg::in_t                in_item,
  output logic [$clog2(MAX_WIDTH)-1:0] rd_col,
  output logic [$clog2(MAX_WIDTH)-1:0] rd_oc,
  output logic [$clog2(MAX_WIDTH)-1:0] rd_ocm1,
  output logic [$clog2(MAX_WIDTH)-1:0] rd_ocp1,
  output cgfm_pkg::s1_ctl_t            s1_ctl,
  output logic [cgfm_pkg::PIX_W-1:0]   s1_pixel,
  output logic [$clog2(MAX_WIDTH)-1:0] s1_col,
  output logic [$clog2(MAX_WIDTH)-1:0] s1_oc,
  output logic [$clog2(MAX_WIDTH)-1:0] s1_ocm1,
  output logic [$clog2(MAX_WIDTH)-1:0] s1_ocp1
);
  import cgfm_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int EW = ((WW > CFG_W) ? WW : CFG_W) + 1;
  localparam int PW = $clog2(MAX_WIDTH + 3);
  localparam int KW = ((PW > EW) ? PW : EW) + 1;
  localparam logic [EW-1:0]    W_MAX    = EW'(MAX_WIDTH);
  localparam logic [CFG_W-1:0] H_MAX    = CFG_W'(CGFM_MAX_HEIGHT);
  localparam logic [PW-1:0]    PEND_MAX = PW'(MAX_WIDTH + 2);

  logic [CFG_W-1:0] frame_width_r,  frame_width_nxt;
  logic [CFG_W-1:0] frame_height_r, frame_height_nxt;
  logic [CW-1:0]    in_column_r,    in_column_nxt;
  logic [ROW_W-1:0] in_row_r,       in_row_nxt;
  logic [CW-1:0]    out_column_r,   out_column_nxt;
  logic [ROW_W-1:0] out_row_r,      out_row_nxt;
  logic [PW-1:0]    pending_r,      pending_nxt;

  s1_ctl_t          s1_ctl_r,  s1_ctl_nxt;
  logic [PIX_W-1:0] s1_pixel_r;
  logic [CW-1:0]    s1_col_r, s1_oc_r, s1_ocm1_r, s1_ocp1_r;

  logic [EW-1:0]    fw_ext;
  logic [EW-1:0]    w_eff;
  logic [CFG_W-1:0] h_eff;
  logic [CW-1:0]    c, c_adv, oc, oc_adv;
  logic [ROW_W-1:0] r, r_adv, orow, orow_adv;
  logic             c_last, r_last, oc_last, orow_last;
  logic [PW-1:0]    pend_inc;
  logic             is_pix, emit, interior, frame_end;

  // clamp the registers to the usable range
  assign fw_ext = EW'(frame_width_r);
  assign w_eff  = (fw_ext == '0) ? EW'(1) : ((fw_ext > W_MAX) ? W_MAX : fw_ext);
  assign h_eff  = (frame_height_r == '0) ? CFG_W'(1) :
                  ((frame_height_r > H_MAX) ? H_MAX : frame_height_r);

  // wrap positions that lie beyond the current bounds
  assign c    = (EW'(in_column_r) >= w_eff) ? '0 : in_column_r;
  assign r    = (CFG_W'(in_row_r) >= h_eff) ? '0 : in_row_r;
  assign oc   = (EW'(out_column_r) >= w_eff) ? '0 : out_column_r;
  assign orow = (CFG_W'(out_row_r) >= h_eff) ? '0 : out_row_r;

  assign c_last    = (EW'(c) + EW'(1)) >= w_eff;
  assign r_last    = (CFG_W'(r) + CFG_W'(1)) >= h_eff;
  assign oc_last   = (EW'(oc) + EW'(1)) >= w_eff;
  assign orow_last = (CFG_W'(orow) + CFG_W'(1)) >= h_eff;

  assign c_adv    = c_last ? '0 : c + CW'(1);
  assign r_adv    = c_last ? (r_last ? '0 : r + ROW_W'(1)) : r;
  assign oc_adv   = oc_last ? '0 : oc + CW'(1);
  assign orow_adv = oc_last ? (orow_last ? '0 : orow + ROW_W'(1)) : orow;

  assign is_pix   = (in_item.kind == KIND_PIXEL);
  assign pend_inc = (pending_r < PEND_MAX) ? pending_r + PW'(1) : pending_r;
  assign emit     = is_pix ? (KW'(pend_inc) > (KW'(w_eff) + KW'(1))) : (pending_r != '0);

  assign interior  = (orow != '0) && ((CFG_W'(orow) + CFG_W'(1)) < h_eff) &&
                     (oc != '0) && ((EW'(oc) + EW'(1)) < w_eff);
  assign frame_end = ((CFG_W'(orow) + CFG_W'(1)) == h_eff) &&
                     ((EW'(oc) + EW'(1)) == w_eff);

  // addresses for the reads issued with the transaction
  assign rd_col  = c;
  assign rd_oc   = oc;
  assign rd_ocm1 = oc - CW'(1);
  assign rd_ocp1 = oc + CW'(1);

  always_comb begin
    frame_width_nxt  = frame_width_r;
    frame_height_nxt = frame_height_r;
    if (cfg_wr) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  frame_width_nxt  = cfg_data;
        REG_FRAME_HEIGHT: frame_height_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    in_column_nxt  = in_column_r;
    in_row_nxt     = in_row_r;
    out_column_nxt = out_column_r;
    out_row_nxt    = out_row_r;
    pending_nxt    = pending_r;
    if (in_accept) begin
      in_column_nxt  = is_pix ? c_adv : c;
      in_row_nxt     = is_pix ? r_adv : r;
      out_column_nxt = emit ? oc_adv : oc;
      out_row_nxt    = emit ? orow_adv : orow;
      if (is_pix) begin
        pending_nxt = emit ? pend_inc - PW'(1) : pend_inc;
      end else begin
        pending_nxt = emit ? pending_r - PW'(1) : pending_r;
      end
    end
  end

  always_comb begin
    s1_ctl_nxt           = s1_ctl_r;
    s1_ctl_nxt.valid     = in_accept;
    if (in_accept) begin
      s1_ctl_nxt.pix       = is_pix;
      s1_ctl_nxt.emit      = emit;
      s1_ctl_nxt.interior  = interior;
      s1_ctl_nxt.frame_end = frame_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= WIDTH_RESET;
      frame_height_r <= HEIGHT_RESET;
      in_column_r    <= '0;
      in_row_r       <= '0;
      out_column_r   <= '0;
      out_row_r      <= '0;
      pending_r      <= '0;
      s1_ctl_r       <= '0;
    end else begin
      frame_width_r  <= frame_width_nxt;
      frame_height_r <= frame_height_nxt;
      in_column_r    <= in_column_nxt;
      in_row_r       <= in_row_nxt;
      out_column_r   <= out_column_nxt;
      out_row_r      <= out_row_nxt;
      pending_r      <= pending_nxt;
      s1_ctl_r       <= s1_ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_pixel_r <= in_item.pixel;
      s1_col_r   <= c;
      s1_oc_r    <= oc;
      s1_ocm1_r  <= rd_ocm1;
      s1_ocp1_r  <= rd_ocp1;
    end
  end

  assign s1_ctl   = s1_ctl_r;
  assign s1_pixel = s1_pixel_r;
  assign s1_col   = s1_col_r;
  assign s1_oc    = s1_oc_r;
  assign s1_ocm1  = s1_ocm1_r;
  assign s1_ocp1  = s1_ocp1_r;

endmodule

[rtl/core/cgfm_datapath.sv]
module cgfm_datapath #(
  parameter int MAX_WIDTH = cgfm_pkg::CGFM_MAX_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  cgfm_pkg::s1_ctl_t            s1_ctl,
  input  logic [cgfm_pkg::PIX_W-1:0]   s1_pixel,
  input  logic [$clog2(MAX_WIDTH)-1:0] s1_col,
  input  logic [$clog2(MAX_WIDTH)-1:0] s1_oc,
  input  logic [$clog2(MAX_WIDTH)-1:0] s1_ocm1,
  input  logic [$clog2(MAX_WIDTH)-1:0] s1_ocp1,
  input  cgfm_pkg::line_pair_t         rd_col_pair,
  input  cgfm_pkg::line_pair_t         rd_oc_pair,
  input  cgfm_pkg::line_pair_t         rd_ocm1_pair,
  input  cgfm_pkg::line_pair_t         rd_ocp1_pair,
  output logic                         wr_en,
  output logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
  output cgfm_pkg::line_pair_t         wr_data,
  output logic                         push,
  output cgfm_pkg::out_t               push_data
);
  import cgfm_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);

  // write of the previous cycle, missed by reads issued at the same edge
  logic             fw_valid_r, fw_valid_nxt;
  logic [CW-1:0]    fw_addr_r;
  line_pair_t       fw_data_r;
  logic [PIX_W-1:0] evicted_r, evicted_nxt;

  line_pair_t       col_pair, oc_pair, ocm1_pair, ocp1_pair;
  logic [PIX_W:0]   grad_sum;
  logic [PIX_W-1:0] grad_sat;

  assign col_pair  = (fw_valid_r && (s1_col  == fw_addr_r)) ? fw_data_r : rd_col_pair;
  assign oc_pair   = (fw_valid_r && (s1_oc   == fw_addr_r)) ? fw_data_r : rd_oc_pair;
  assign ocm1_pair = (fw_valid_r && (s1_ocm1 == fw_addr_r)) ? fw_data_r : rd_ocm1_pair;
  assign ocp1_pair = (fw_valid_r && (s1_ocp1 == fw_addr_r)) ? fw_data_r : rd_ocp1_pair;

  // above comes from the pixel evicted by the last earlier pixel transaction
  assign grad_sum = {1'b0, absdiff(evicted_r, oc_pair.middle)} +
                    {1'b0, absdiff(ocp1_pair.middle, ocm1_pair.above)};
  assign grad_sat = grad_sum[PIX_W] ? SAT_LIMIT : grad_sum[PIX_W-1:0];

  // shift the column down one row and drop the new pixel in
  assign wr_en          = s1_ctl.valid && s1_ctl.pix;
  assign wr_addr        = s1_col;
  assign wr_data.above  = col_pair.middle;
  assign wr_data.middle = s1_pixel;

  assign push                = s1_ctl.valid && s1_ctl.emit;
  assign push_data.gradient  = s1_ctl.interior ? grad_sat : '0;
  assign push_data.frame_end = s1_ctl.frame_end;

  assign fw_valid_nxt = wr_en;
  assign evicted_nxt  = wr_en ? col_pair.above : evicted_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_valid_r <= 1'b0;
      evicted_r  <= '0;
    end else begin
      fw_valid_r <= fw_valid_nxt;
      evicted_r  <= evicted_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      fw_addr_r <= wr_addr;
      fw_data_r <= wr_data;
    end
  end

endmodule

[rtl/core/cgfm_out_fifo.sv]
module cgfm_out_fifo (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      push,
  input  cgfm_pkg::out_t                            push_data,
  input  logic                                      pop,
  output logic                                      head_valid,
  output cgfm_pkg::out_t                            head_data,
  output logic [$clog2(cgfm_pkg::OUT_DEPTH+1)-1:0]  count
);
  import cgfm_pkg::*;

  localparam int PTR_W = $clog2(OUT_DEPTH);
  localparam int CNT_W = $clog2(OUT_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(OUT_DEPTH - 1);

  out_t             slot_r [OUT_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r,  count_nxt;
  logic             do_pop;

  assign do_pop     = pop && (count_r != '0);
  assign wr_ptr_nxt = push ? ((wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1)) : wr_ptr_r;
  assign rd_ptr_nxt = do_pop ? ((rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1)) : rd_ptr_r;

  always_comb begin
    count_nxt = count_r;
    case ({push, do_pop})
      2'b10:   count_nxt = count_r + CNT_W'(1);
      2'b01:   count_nxt = count_r - CNT_W'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  assign head_valid = (count_r != '0);
  assign head_data  = slot_r[rd_ptr_r];
  assign count      = count_r;

endmodule

[rtl/core/cross_gradient_focus_map.sv]
// A result passes the modify-stage registers and the output queue before out_valid offers it.
// Throughput: one transaction per cycle, pixel or drain, while in_stall stays low.
// A pixel causes the result for the position one row plus one pixel behind it.
// Reset (rst_n low, synchronous): positions, pending count and output queue clear and the
// registers return to 640 x 480; the line memories keep their contents and need no clearing pass.
`include "cross_gradient_focus_map_defines.svh"

module cross_gradient_focus_map #(
  parameter int MAX_WIDTH = cgfm_pkg::CGFM_MAX_WIDTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  cgfm_pkg::in_t              in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output cgfm_pkg::out_t             out_data,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  cgfm_pkg::cfg_reg_t         cfg_index,
  input  logic [cgfm_pkg::CFG_W-1:0] cfg_data
);
  import cgfm_pkg::*;

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int CNT_W = $clog2(OUT_DEPTH + 1);

  // Pipeline:
  //   issue  - a transaction is taken; positions and the pending count advance
  //            and the four line memory reads go out (column, centre, left, right).
  //   modify - read data returns, the previous cycle's write is forwarded over it,
  //            the gradient is formed and the column written back.
  //   queue  - results wait in a three-entry queue so input keeps flowing while
  //            the consumer stalls.
  // The two memories hold identical copies of the line pair, one per read-port pair.

  logic in_accept;
  logic cfg_wr;

  logic [CW-1:0] rd_col, rd_oc, rd_ocm1, rd_ocp1;
  logic [CW-1:0] s1_col, s1_oc, s1_ocm1, s1_ocp1;
  s1_ctl_t          s1_ctl;
  logic [PIX_W-1:0] s1_pixel;

  line_pair_t    col_pair, oc_pair, ocm1_pair, ocp1_pair;
  logic          wr_en;
  logic [CW-1:0] wr_addr;
  line_pair_t    wr_data;

  logic             push;
  out_t             push_data;
  logic             pop;
  logic [CNT_W-1:0] fifo_count;

  // Hold input whenever the queue could not absorb the transaction in flight plus one more.
  assign in_stall  = !rst_n ||
                     (({1'b0, fifo_count} + (CNT_W+1)'(s1_ctl.valid)) >= (CNT_W+1)'(OUT_DEPTH));
  assign in_accept = in_valid && !in_stall;

  // Registers take a write in any cycle out of reset.
  assign cfg_ready = rst_n;
  assign cfg_wr    = cfg_valid && cfg_ready;

  assign pop = out_valid && !out_stall;

  cgfm_ctrl #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr    (cfg_wr),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_accept (in_accept),
    .in_item   (in_data),
    .rd_col    (rd_col),
    .rd_oc     (rd_oc),
    .rd_ocm1   (rd_ocm1),
    .rd_ocp1   (rd_ocp1),
    .s1_ctl    (s1_ctl),
    .s1_pixel  (s1_pixel),
    .s1_col    (s1_col),
    .s1_oc     (s1_oc),
    .s1_ocm1   (s1_ocm1),
    .s1_ocp1   (s1_ocp1)
  );

  // copy A: current column and output centre
  cgfm_line_mem #(
    .DEPTH (MAX_WIDTH)
  ) u_mem_a (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr_a (rd_col),
    .rd_addr_b (rd_oc),
    .rd_data_a (col_pair),
    .rd_data_b (oc_pair)
  );

  // copy B: left and right neighbours of the output centre
  cgfm_line_mem #(
    .DEPTH (MAX_WIDTH)
  ) u_mem_b (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr_a (rd_ocm1),
    .rd_addr_b (rd_ocp1),
    .rd_data_a (ocm1_pair),
    .rd_data_b (ocp1_pair)
  );

  cgfm_datapath #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .s1_ctl       (s1_ctl),
    .s1_pixel     (s1_pixel),
    .s1_col       (s1_col),
    .s1_oc        (s1_oc),
    .s1_ocm1      (s1_ocm1),
    .s1_ocp1      (s1_ocp1),
    .rd_col_pair  (col_pair),
    .rd_oc_pair   (oc_pair),
    .rd_ocm1_pair (ocm1_pair),
    .rd_ocp1_pair (ocp1_pair),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .push         (push),
    .push_data    (push_data)
  );

  cgfm_out_fifo u_out_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  (push_data),
    .pop        (pop),
    .head_valid (out_valid),
    .head_data  (out_data),
    .count      (fifo_count)
  );

  // Drop nothing: a push into a full queue would lose a result.
  `CGFM_ASSERT_NOW(a_queue_no_overflow, push && !pop, fifo_count != CNT_W'(OUT_DEPTH), "result queue overflow")
  // The last position of a frame is a corner, so its gradient is zero.
  `CGFM_ASSERT_NOW(a_frame_end_border, out_valid && out_data.frame_end, out_data.gradient == '0, "frame end with non-zero gradient")
  // Advance every accepted transaction into the modify stage on the next cycle.
  `CGFM_ASSERT_NEXT(a_accept_to_modify, in_accept, s1_ctl.valid, "accepted transaction lost before modify stage")
  // Drain ticks leave the line memories untouched.
  `CGFM_ASSERT_NOW(a_drain_no_write, s1_ctl.valid && !s1_ctl.pix, !wr_en, "drain transaction wrote a line memory")

endmodule

[tb/cross_gradient_focus_map_tb.sv]
module cross_gradient_focus_map_tb;
  import cgfm_pkg::*;

  // Line buffer depth of the block; positions lie below it, the pending count at most two above it.
  localparam int unsigned DEPTH        = CGFM_MAX_WIDTH;
  // Cycles to hold off after the last expected result, so that transactions which
  // cause no result have left the pipeline before the next register write.
  localparam int unsigned PIPE_SLACK   = 8;
  // Upper bound on cycles spent waiting for outstanding results in one pause.
  localparam int unsigned SETTLE_LIMIT = 20000;
  // Minimum number of random pixel transactions in the mixed-size part.
  localparam int unsigned RANDOM_PIXELS = 600;
  // Pixels streamed at each of the largest frame sizes.
  localparam int unsigned PARTIAL_PIXELS = 60;

  typedef enum {STALL_NONE, STALL_RANDOM, STALL_PERIODIC, STALL_LONG} stall_mode_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  in_t                in_data;
  logic               out_valid;
  logic               out_stall;
  out_t               out_data;
  logic               cfg_valid;
  logic               cfg_ready;
  cfg_reg_t           cfg_index;
  logic [CFG_W-1:0]   cfg_data;

  cross_gradient_focus_map DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // ---------------------------------------------------------------------------
  // Gradient predictor: own copy of the registers, line buffers and positions.
  // The written flags track which buffer entries hold real pixels since reset,
  // so that a drain is never sent where it would read an undefined entry.
  // ---------------------------------------------------------------------------
  logic [CFG_W-1:0] width_reg  = WIDTH_RESET;
  logic [CFG_W-1:0] height_reg = HEIGHT_RESET;
  bit [PIX_W-1:0]   row_two_back [DEPTH];
  bit [PIX_W-1:0]   row_one_back [DEPTH];
  bit               two_back_written [DEPTH];
  bit               one_back_written [DEPTH];
  bit [PIX_W-1:0]   evicted_px;
  bit               evicted_written;
  int unsigned      in_col, in_row, out_col, out_row;
  int unsigned      pending_cnt;

  out_t             gradients_due [$];
  out_t             oldest_due;
  int unsigned      result_idx;
  int unsigned      error_count;
  int unsigned      burst_left;

  function automatic int unsigned width_eff();
    if (width_reg == '0) return 1;
    if (width_reg > DEPTH) return DEPTH;
    return width_reg;
  endfunction

  function automatic int unsigned height_eff();
    if (height_reg == '0) return 1;
    if (height_reg > CGFM_MAX_HEIGHT) return CGFM_MAX_HEIGHT;
    return height_reg;
  endfunction

  function automatic int unsigned px_distance(input int unsigned a, input int unsigned b);
    return (a > b) ? a - b : b - a;
  endfunction

  // Advance a raster position, wrapping the column at the width and the row at the height.
  task automatic step_position(inout int unsigned col, inout int unsigned row,
                               input int unsigned w, input int unsigned h);
    if (col + 1 >= w) begin
      col = 0;
      row = (row + 1 >= h) ? 0 : row + 1;
    end else begin
      col = col + 1;
    end
  endtask

  // True when a drain now would compute an interior gradient from a buffer entry
  // that no pixel has written since reset.
  function automatic bit drain_reads_unknown();
    int unsigned w, h, oc, orow;
    w    = width_eff();
    h    = height_eff();
    oc   = (out_col >= w) ? 0 : out_col;
    orow = (out_row >= h) ? 0 : out_row;
    if (pending_cnt == 0) return 1'b0;
    if (orow == 0 || orow + 1 >= h || oc == 0 || oc + 1 >= w) return 1'b0;
    return !(two_back_written[oc-1] && one_back_written[oc] && one_back_written[oc+1] &&
             evicted_written);
  endfunction

  // Work out the result (if any) of one accepted transaction and queue it.
  task automatic cross_gradient_step(input in_t item);
    int unsigned w, h, oc, orow, c, grad;
    bit          emit;
    bit [PIX_W-1:0] above;
    out_t        due;
    w     = width_eff();
    h     = height_eff();
    above = evicted_px;
    grad  = 0;
    // positions may lie beyond fresh bounds: wrap them
    if (in_col >= w) in_col = 0;
    if (in_row >= h) in_row = 0;
    if (out_col >= w) out_col = 0;
    if (out_row >= h) out_row = 0;
    oc   = out_col;
    orow = out_row;
    c    = in_col;
    if (item.kind == KIND_PIXEL) begin
      if (pending_cnt < DEPTH + 2) pending_cnt++;
      emit = (pending_cnt > w + 1);
    end else begin
      emit = (pending_cnt > 0);
    end
    if (emit && orow != 0 && orow + 1 < h && oc != 0 && oc + 1 < w) begin
      grad = px_distance(above, row_one_back[oc]) +
             px_distance(row_one_back[oc+1], row_two_back[oc-1]);
      if (grad > SAT_LIMIT) grad = SAT_LIMIT;
    end
    if (item.kind == KIND_PIXEL) begin
      evicted_px          = row_two_back[c];
      evicted_written     = two_back_written[c];
      row_two_back[c]     = row_one_back[c];
      two_back_written[c] = one_back_written[c];
      row_one_back[c]     = item.pixel;
      one_back_written[c] = 1'b1;
      step_position(in_col, in_row, w, h);
    end
    if (emit) begin
      pending_cnt--;
      due.gradient  = grad[PIX_W-1:0];
      due.frame_end = (orow + 1 == h) && (oc + 1 == w);
      gradients_due.push_back(due);
      step_position(out_col, out_row, w, h);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Mismatch reporting and result checking.
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    error_count++;
  endtask

  // Compare every accepted result transaction with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (gradients_due.size() == 0) begin
        report_mismatch($sformatf("result %0d unexpected: gradient=%0d frame_end=%0b",
                                  result_idx, out_data.gradient, out_data.frame_end));
      end else begin
        oldest_due = gradients_due.pop_front();
        if (out_data.gradient !== oldest_due.gradient)
          report_mismatch($sformatf("result %0d gradient %0d, expected %0d", result_idx,
                                    out_data.gradient, oldest_due.gradient));
        if (out_data.frame_end !== oldest_due.frame_end)
          report_mismatch($sformatf("result %0d frame_end %0b, expected %0b", result_idx,
                                    out_data.frame_end, oldest_due.frame_end));
      end
      result_idx++;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver back-pressure: switch between quiet, random, periodic and long-stall
  // stretches, each of random length.
  // ---------------------------------------------------------------------------
  initial begin
    stall_mode_t mode;
    int unsigned stretch_left;
    int unsigned stall_run;
    out_stall    = 1'b0;
    mode         = STALL_NONE;
    stretch_left = 0;
    stall_run    = 0;
    forever begin
      @(negedge clk);
      if (stretch_left == 0) begin
        mode         = stall_mode_t'($urandom_range(0, 3));
        stretch_left = $urandom_range(40, 300);
      end
      stretch_left--;
      case (mode)
        STALL_NONE: begin
          out_stall <= 1'b0;
        end
        STALL_RANDOM: begin
          out_stall <= ($urandom_range(0, 2) == 0);
        end
        STALL_PERIODIC: begin
          out_stall <= (stretch_left % 4 == 0);
        end
        default: begin
          // now and then hold stall over a run of random length
          if (stall_run == 0 && $urandom_range(0, 15) == 0) stall_run = $urandom_range(1, 10);
          if (stall_run > 0) begin
            stall_run--;
            out_stall <= 1'b1;
          end else begin
            out_stall <= 1'b0;
          end
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers. Every task is entered and left at a falling edge.
  // ---------------------------------------------------------------------------
  function automatic in_t pixel_item(input logic [PIX_W-1:0] value);
    in_t item;
    item.kind  = KIND_PIXEL;
    item.pixel = value;
    return item;
  endfunction

  // The pixel field of a drain is ignored: fill it with noise.
  function automatic in_t drain_item();
    in_t item;
    item.kind  = KIND_DRAIN;
    item.pixel = PIX_W'($urandom_range(0, 255));
    return item;
  endfunction

  // Bias towards the extremes so that saturation and zero differences come up often.
  function automatic logic [PIX_W-1:0] random_pixel();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return SAT_LIMIT;
      default: return PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  // Offer one input transaction, idling in bursts, and predict it once accepted.
  // Valid is left high on return so that a following transaction can go back to back.
  task automatic send_item(input in_t item);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 400)
                                               : $urandom_range(1, 16);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    cross_gradient_step(item);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    if (idx == REG_FRAME_WIDTH) width_reg = value;
    else height_reg = value;
  endtask

  // Write both registers back to back, then drop the write request.
  task automatic set_frame_size(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
    cfg_valid <= 1'b0;
  endtask

  // Stream whole frames of random pixels. With noise on, occasionally slip a drain
  // into the middle of a frame, but only where it reads defined buffer entries.
  task automatic send_frames(input int unsigned frames, input bit noisy);
    int unsigned total;
    total = frames * width_eff() * height_eff();
    for (int unsigned i = 0; i < total; i++) begin
      if (noisy && pending_cnt > 0 && $urandom_range(0, 29) == 0 && !drain_reads_unknown())
        send_item(drain_item());
      send_item(pixel_item(random_pixel()));
    end
  endtask

  // Stream a run of random pixels without regard to frame boundaries.
  task automatic send_pixels(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) send_item(pixel_item(random_pixel()));
  endtask

  // Push out what the last frame still owes.
  task automatic drain_pending();
    while (pending_cnt > 0) send_item(drain_item());
  endtask

  // Drop valid, wait for every expected result, then let the pipeline empty.
  task automatic settle();
    int unsigned waited;
    waited = 0;
    in_valid <= 1'b0;
    while (gradients_due.size() != 0 && waited < SETTLE_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (PIPE_SLACK) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Smallest frame with an interior pixel: once with a centre that saturates,
  // once with a mild one, back to back; then a drain with nothing pending.
  task automatic test_saturated_interior();
    logic [PIX_W-1:0] sharp [0:8];
    logic [PIX_W-1:0] mild  [0:8];
    sharp = '{8'd0, 8'd255, 8'd0, 8'd0, 8'd128, 8'd255, 8'd0, 8'd0, 8'd0};
    mild  = '{8'd10, 8'd20, 8'd30, 8'd40, 8'd50, 8'd60, 8'd70, 8'd80, 8'd90};
    set_frame_size(13'd3, 13'd3);
    for (int i = 0; i < 9; i++) send_item(pixel_item(sharp[i]));
    for (int i = 0; i < 9; i++) send_item(pixel_item(mild[i]));
    drain_pending();
    send_item(drain_item());
    settle();
  endtask

  // Zero width and height act as one: every result ends a frame.
  task automatic test_degenerate_size();
    set_frame_size('0, '0);
    send_item(pixel_item(SAT_LIMIT));
    drain_pending();
    settle();
  endtask

  // Mostly small frames, one to three back to back per setting, some shorter than a row
  // plus one pixel, with occasional stray drains.
  task automatic test_random_frames();
    int unsigned pixels_sent, w, h, frames;
    pixels_sent = 0;
    while (pixels_sent < RANDOM_PIXELS) begin
      case ($urandom_range(0, 9))
        0:       w = 1;
        1:       w = 2;
        default: w = $urandom_range(3, 12);
      endcase
      case ($urandom_range(0, 9))
        0:       h = 1;
        1:       h = 2;
        default: h = $urandom_range(3, 8);
      endcase
      set_frame_size(CFG_W'(w), CFG_W'(h));
      frames = $urandom_range(1, 3);
      send_frames(frames, $urandom_range(0, 3) != 0);
      pixels_sent += frames * w * h;
      drain_pending();
      if ($urandom_range(0, 2) == 0) send_item(drain_item());
      settle();
    end
  endtask

  // Full-width rows, written exactly and clamped from the largest register value.
  // Only the start of the first row is streamed, so every result lies on the border
  // and none comes out before the drains.
  task automatic test_max_width();
    set_frame_size(CFG_W'(CGFM_MAX_WIDTH), 13'd3);
    send_pixels(PARTIAL_PIXELS);
    drain_pending();
    settle();
    set_frame_size({CFG_W{1'b1}}, 13'd2);
    send_pixels(PARTIAL_PIXELS);
    drain_pending();
    settle();
  endtask

  // Tallest frame, written exactly and clamped, on a single column: the leftover
  // column position wraps to the start, and no result may end the frame early.
  task automatic test_max_height();
    set_frame_size(13'd1, CFG_W'(CGFM_MAX_HEIGHT));
    send_pixels(PARTIAL_PIXELS);
    drain_pending();
    settle();
    set_frame_size(13'd1, {CFG_W{1'b1}});
    send_pixels(PARTIAL_PIXELS);
    drain_pending();
    settle();
  endtask

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    cfg_valid   = 1'b0;
    cfg_index   = REG_FRAME_WIDTH;
    cfg_data    = '0;
    result_idx  = 0;
    error_count = 0;
    burst_left  = 0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_saturated_interior();
    test_degenerate_size();
    test_random_frames();
    test_max_width();
    test_max_height();

    settle();
    if (gradients_due.size() != 0)
      report_mismatch($sformatf("%0d expected results never arrived", gradients_due.size()));
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #40000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
